// ===== design/gptt_pkg.sv =====
// Package for the grouped periodic timer table.
// Holds sizes, codes, record and request/response types. No dependencies.
package gptt_pkg;

   localparam int SLOTS  = 16;
   localparam int TIMERS = 32;
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [1:0] ACT_START    = 2'd0;
   localparam logic [1:0] ACT_STOP     = 2'd1;
   localparam logic [1:0] ACT_STOP_ALL = 2'd2;
   localparam logic [1:0] ACT_TICK     = 2'd3;

   localparam logic [1:0] KIND_DONE   = 2'd0;
   localparam logic [1:0] KIND_FULL   = 2'd1;
   localparam logic [1:0] KIND_EXPIRY = 2'd2;

   typedef logic [TIMERS-1:0] mask_type;
   typedef logic [IDX_W-1:0]  idx_type;

   typedef struct packed {
      logic [30:0] period;
      logic [47:0] deadline;
      mask_type    members;
      mask_type    objk;
   } slot_rec_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [4:0]  timer_id;
      logic [30:0] interval_ms;
      logic        is_object;
      logic [47:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  slot;
      logic [30:0] period_ms;
      logic [31:0] member_mask;
      logic [31:0] object_mask;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLACE,
      ST_TICK,
      ST_FINISH
   } state_type;

   // Placement target for the second pass of a start.
   typedef struct packed {
      logic    rejoin;
      idx_type target;
   } place_type;

   function automatic logic [31:0] to_mask32(mask_type m);
      logic [63:0] w;
      w = 64'(m);
      return w[31:0];
   endfunction

endpackage

// ===== design/gptt_cell.sv =====
// One slot cell of the rotating slot chain.
// Depends on gptt_pkg for the slot record type.
module gptt_cell import gptt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         shift_en,
   input  slot_rec_type d_in,
   output slot_rec_type q
);

   slot_rec_type rec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= '0;
      end else if (shift_en) begin
         rec_ff <= d_in;
      end
   end

   assign q = rec_ff;

endmodule

// ===== design/gptt_head.sv =====
// Head unit: updates the slot record at the front of the chain.
// Depends on gptt_pkg for the record, request and state types.
module gptt_head import gptt_pkg::*; (
   input  state_type    state,
   input  req_type      req,
   input  idx_type      idx,
   input  place_type    place,
   input  slot_rec_type rec_in,
   output slot_rec_type rec_out,
   output logic         expire,
   output logic         is_match,
   output logic         is_free
);

   logic     id_ok;
   mask_type bit_m;
   logic     everywhere;
   logic     same_per;

   always_comb begin
      id_ok      = ({2'b00, req.timer_id} < 7'(TIMERS));
      bit_m      = mask_type'(1) << req.timer_id;
      same_per   = (req.interval_ms != '0) && (rec_in.period == req.interval_ms);
      everywhere = req.is_object ||
                   ((req.action == ACT_STOP) && (req.interval_ms == '0));
      rec_out    = rec_in;
      expire     = 1'b0;

      unique case (state)
         ST_SCAN: begin
            if (req.action == ACT_STOP_ALL) begin
               if (same_per) begin
                  rec_out.period  = '0;
                  rec_out.members = '0;
                  rec_out.objk    = '0;
               end
            end else if (id_ok && (everywhere || same_per)) begin
               rec_out.members = rec_in.members & ~bit_m;
               rec_out.objk    = rec_in.objk & ~bit_m;
               if (rec_out.members == '0) begin
                  rec_out.period = '0;
                  rec_out.objk   = '0;
               end
            end
         end
         ST_PLACE: begin
            if (idx == place.target) begin
               if (place.rejoin) begin
                  rec_out.members = rec_in.members | bit_m;
                  rec_out.objk    = req.is_object ? (rec_in.objk | bit_m)
                                                  : (rec_in.objk & ~bit_m);
               end else begin
                  rec_out.period   = req.interval_ms;
                  rec_out.members  = bit_m;
                  rec_out.objk     = req.is_object ? bit_m : '0;
                  rec_out.deadline = req.now_ms + 48'(req.interval_ms);
               end
            end
         end
         ST_TICK: begin
            if ((rec_in.period != '0) && (req.now_ms > rec_in.deadline)) begin
               expire           = 1'b1;
               rec_out.deadline = rec_in.deadline + 48'(rec_in.period);
            end
         end
         default: begin
            rec_out = rec_in;
         end
      endcase

      is_match = (req.interval_ms != '0) && (rec_out.period == req.interval_ms);
      is_free  = (rec_out.period == '0);
   end

endmodule

// ===== design/grouped_periodic_timer_table_top.sv =====
// Grouped periodic timer table, top level.
// Stop and stop-all make one pass over the chain; a start makes a removal pass
// and, if the timer can be placed, a placement pass; a tick makes one pass and
// waits on output stalls. One request at a time; the chain rotation (one slot
// per cycle past the head unit, paused while a tick's output is blocked) sets
// this. Synchronous reset frees every slot and clears state, index and flags.
module grouped_periodic_timer_table_top import gptt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type    state_ff, state_in;
   req_type      req_ff, req_in;
   idx_type      idx_ff, idx_in;
   logic         match_ff, match_in, free_ff, free_in;
   idx_type      match_idx_ff, match_idx_in, free_idx_ff, free_idx_in;
   logic [1:0]   kind_ff, kind_in;
   logic         held_valid_ff, held_valid_in;
   rsp_type      held_ff, held_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   logic         step;
   logic         out_free;
   logic         last_idx;
   place_type    place;
   slot_rec_type cell_q [SLOTS];
   slot_rec_type head_out;
   logic         expire, is_match, is_free;
   logic         start_ok;
   rsp_type      exp_rsp;

   // Slot chain: each cell hands its record to the one below; the head
   // unit's result re-enters at the top, so after SLOTS steps all slots
   // are back home.
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      slot_rec_type d;
      if (i == SLOTS - 1) begin : g_top
         assign d = head_out;
      end else begin : g_mid
         assign d = cell_q[i+1];
      end
      gptt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (step),
         .d_in     (d),
         .q        (cell_q[i])
      );
   end

   assign place.rejoin = match_ff;
   assign place.target = match_ff ? match_idx_ff : free_idx_ff;

   gptt_head u_head (
      .state    (state_ff),
      .req      (req_ff),
      .idx      (idx_ff),
      .place    (place),
      .rec_in   (cell_q[0]),
      .rec_out  (head_out),
      .expire   (expire),
      .is_match (is_match),
      .is_free  (is_free)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last_idx = (idx_ff == IDX_W'(SLOTS - 1));

   // Step the chain in every scan or place state; a tick waits while output is blocked.
   assign step = (state_ff == ST_SCAN) || (state_ff == ST_PLACE) ||
                 ((state_ff == ST_TICK) && out_free);

   assign start_ok = (req_ff.action == ACT_START) && (req_ff.interval_ms != '0) &&
                     ({2'b00, req_ff.timer_id} < 7'(TIMERS));

   always_comb begin
      exp_rsp.kind        = KIND_EXPIRY;
      exp_rsp.slot        = 4'(idx_ff);
      exp_rsp.period_ms   = cell_q[0].period;
      exp_rsp.member_mask = to_mask32(cell_q[0].members);
      exp_rsp.object_mask = to_mask32(cell_q[0].objk);
      exp_rsp.last        = 1'b0;
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      match_in      = match_ff;
      match_idx_in  = match_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      kind_in       = kind_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               idx_in        = '0;
               match_in      = 1'b0;
               free_in       = 1'b0;
               kind_in       = KIND_DONE;
               held_valid_in = 1'b0;
               state_in      = (req_data.action == ACT_TICK) ? ST_TICK : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Remember the first matching and the first free slot after removal.
            if (is_match && !match_ff) begin
               match_in     = 1'b1;
               match_idx_in = idx_ff;
            end
            if (is_free && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = idx_ff;
            end
            idx_in = idx_ff + 1'b1;
            if (last_idx) begin
               idx_in = '0;
               if (start_ok && (match_in || free_in)) begin
                  state_in = ST_PLACE;
               end else begin
                  if (start_ok) begin
                     kind_in = KIND_FULL;
                  end
                  state_in = ST_FINISH;
               end
            end
         end
         ST_PLACE: begin
            idx_in = idx_ff + 1'b1;
            if (last_idx) begin
               idx_in   = '0;
               state_in = ST_FINISH;
            end
         end
         ST_TICK: begin
            if (step) begin
               // Hold one expiry back so the final one can carry last.
               if (expire) begin
                  if (held_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = held_ff;
                  end
                  held_valid_in = 1'b1;
                  held_in       = exp_rsp;
               end
               idx_in = idx_ff + 1'b1;
               if (last_idx) begin
                  idx_in   = '0;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (held_valid_ff) begin
                  rsp_in = held_ff;
               end else begin
                  rsp_in      = '0;
                  rsp_in.kind = kind_ff;
               end
               rsp_in.last   = 1'b1;
               held_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         match_ff      <= 1'b0;
         free_ff       <= 1'b0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         match_ff      <= match_in;
         free_ff       <= free_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      kind_ff      <= kind_in;
      held_ff      <= held_in;
      rsp_ff       <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== test/tb_grouped_periodic_timer_table_top.sv =====
// Testbench for the grouped periodic timer table: drives start, stop, stop-all
// and tick requests and checks every response against a built-in table model.
// Depends on gptt_pkg and grouped_periodic_timer_table_top.
module tb_grouped_periodic_timer_table_top;
   import gptt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Timer table model plus the queue of responses it predicts.
   class timer_table_scoreboard;
      logic [30:0] period [SLOTS];
      logic [47:0] deadline [SLOTS];
      logic [31:0] members [SLOTS];
      logic [31:0] objk [SLOTS];
      rsp_type     pending_rsp [$];

      function void clear();
         for (int s = 0; s < SLOTS; s++) begin
            period[s] = '0;
            deadline[s] = '0;
            members[s] = '0;
            objk[s] = '0;
         end
      endfunction

      function void drop_timer(logic [31:0] bit_m, bit everywhere, logic [30:0] per);
         for (int s = 0; s < SLOTS; s++) begin
            if (everywhere || (per != 0 && period[s] == per)) begin
               members[s] &= ~bit_m;
               objk[s] &= ~bit_m;
               if (members[s] == 0) begin
                  period[s] = '0;
                  objk[s] = '0;
               end
            end
         end
      endfunction

      function void note_request(req_type r);
         rsp_type     o;
         logic [31:0] bit_m;
         bit          placed;
         int          n;
         o = '0;
         bit_m = 32'd1 << r.timer_id;
         n = 0;
         if (r.action == ACT_TICK) begin
            for (int s = 0; s < SLOTS; s++) begin
               if (period[s] != 0 && r.now_ms > deadline[s]) begin
                  deadline[s] = deadline[s] + 48'(period[s]);
                  o = '0;
                  o.kind = KIND_EXPIRY;
                  o.slot = 4'(s);
                  o.period_ms = period[s];
                  o.member_mask = members[s];
                  o.object_mask = objk[s];
                  pending_rsp.push_back(o);
                  n++;
               end
            end
            if (n == 0) pending_rsp.push_back('0);
            pending_rsp[pending_rsp.size()-1].last = 1'b1;
            return;
         end
         if (r.action == ACT_STOP_ALL) begin
            if (r.interval_ms != 0)
               for (int s = 0; s < SLOTS; s++)
                  if (period[s] == r.interval_ms) begin
                     period[s] = '0;
                     members[s] = '0;
                     objk[s] = '0;
                  end
         end else if (r.action == ACT_STOP) begin
            drop_timer(bit_m, r.is_object || r.interval_ms == 0, r.interval_ms);
         end else begin
            drop_timer(bit_m, r.is_object, r.interval_ms);
            if (r.interval_ms != 0) begin
               placed = 0;
               for (int s = 0; s < SLOTS && !placed; s++)
                  if (period[s] == r.interval_ms) begin
                     members[s] |= bit_m;
                     if (r.is_object) objk[s] |= bit_m;
                     else objk[s] &= ~bit_m;
                     placed = 1;
                  end
               for (int s = 0; s < SLOTS && !placed; s++)
                  if (period[s] == 0) begin
                     period[s] = r.interval_ms;
                     members[s] = bit_m;
                     objk[s] = r.is_object ? bit_m : 32'd0;
                     deadline[s] = r.now_ms + 48'(r.interval_ms);
                     placed = 1;
                  end
               if (!placed) o.kind = KIND_FULL;
            end
         end
         o.last = 1'b1;
         pending_rsp.push_back(o);
      endfunction

      // Return a one-line complaint, or an empty string on a match.
      function string check_response(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) return $sformatf("unexpected response %p", got);
         want = pending_rsp.pop_front();
         if (got.kind != want.kind) return $sformatf("kind %0d want %0d", got.kind, want.kind);
         if (got.slot != want.slot) return $sformatf("slot %0d want %0d", got.slot, want.slot);
         if (got.period_ms != want.period_ms)
            return $sformatf("period %0d want %0d", got.period_ms, want.period_ms);
         if (got.member_mask != want.member_mask)
            return $sformatf("members %h want %h", got.member_mask, want.member_mask);
         if (got.object_mask != want.object_mask)
            return $sformatf("objects %h want %h", got.object_mask, want.object_mask);
         if (got.last != want.last) return $sformatf("last %0d want %0d", got.last, want.last);
         return "";
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   timer_table_scoreboard sb = new();
   int      error_count = 0;
   longint  cycle_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   bit      hold_off = 0;
   logic [47:0] clock_ms = 48'd100;
   logic [30:0] interval_pool [6] = '{31'd1, 31'd3, 31'd10, 31'd50, 31'd1000, 31'h7FFFFFFF};

   grouped_periodic_timer_table_top u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Watchdog: the slowest run is far below this bound.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Response side: check each accepted response, then pick the next stall.
   always @(posedge clock) begin
      string msg;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            msg = sb.check_response(rsp_data);
            if (msg != "") report_mismatch(msg);
         end
         rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Drive one request; drop valid only while idling, hold it until accepted.
   task automatic send_request(req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
   endtask

   function automatic req_type make_req(logic [1:0] act, int id, logic [30:0] iv, bit obj,
                                        logic [47:0] now);
      req_type r;
      r.action = act;
      r.timer_id = 5'(id);
      r.interval_ms = iv;
      r.is_object = obj;
      r.now_ms = now;
      return r;
   endfunction

   // Mostly well-formed activity: starts and stops on a small set of intervals,
   // ticks with time moving forward; now and then a wild value.
   function automatic req_type random_req();
      req_type     r;
      int          pick;
      logic [30:0] iv;
      pick = $urandom_range(99);
      iv = ($urandom_range(9) == 0) ? 31'($urandom) : interval_pool[$urandom_range(4)];
      if ($urandom_range(19) == 0) iv = '0;
      if (pick < 40)
         r = make_req(ACT_START, $urandom_range(31), iv, 1'($urandom_range(1)), clock_ms);
      else if (pick < 58)
         r = make_req(ACT_STOP, $urandom_range(31), iv, 1'($urandom_range(1)), '0);
      else if (pick < 63) r = make_req(ACT_STOP_ALL, $urandom_range(31), iv, 0, '0);
      else begin
         clock_ms = clock_ms + 48'($urandom_range(30));
         r = make_req(ACT_TICK, 0, '0, 0, clock_ms);
      end
      if ($urandom_range(29) == 0) r.now_ms = 48'({$urandom, $urandom});
      return r;
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, every action, zero intervals, full table, idle tick.
      send_request(make_req(ACT_TICK, 0, '0, 0, 48'hFFFF_FFFF_FFFF));
      send_request(make_req(ACT_START, 0, 31'd0, 0, 48'd5));
      send_request(make_req(ACT_START, 31, 31'h7FFFFFFF, 1, 48'hFFFF_FFFF_FFFF));
      send_request(make_req(ACT_START, 5, 31'd1, 1, 48'd0));
      send_request(make_req(ACT_START, 6, 31'd1, 0, 48'd0));
      for (int i = 0; i < 15; i++)
         send_request(make_req(ACT_START, i + 7, 31'(i + 2), i[0], 48'd10));
      send_request(make_req(ACT_TICK, 0, '0, 0, 48'd1000));
      send_request(make_req(ACT_STOP, 5, 31'd0, 0, '0));
      send_request(make_req(ACT_STOP, 31, 31'd7, 0, '0));
      send_request(make_req(ACT_STOP_ALL, 0, 31'd0, 0, '0));
      send_request(make_req(ACT_STOP_ALL, 0, 31'd1, 0, '0));
      send_request(make_req(ACT_TICK, 0, '0, 0, 48'hFFFF_FFFF_FFFF));
      send_request(make_req(ACT_STOP, 31, 31'h7FFFFFFF, 1, '0));

      // Random: three phases (the last with no idling), the first with a long receiver hold-off.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 71 : 0;
         recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 19 : 0;
         if (phase == 0)
            fork
               begin
                  hold_off = 1;
                  repeat (300) @(posedge clock);
                  hold_off = 0;
               end
            join_none
         for (int i = 0; i < 117; i++) send_request(random_req());
         if (phase == 0) begin
            // After the first phase, clear slots on the pool intervals so starts keep finding free slots.
            for (int s = 0; s < 6; s++)
               send_request(make_req(ACT_STOP_ALL, 0, interval_pool[s], 0, '0));
         end
      end
      req_valid <= 1'b0;

      recv_idle_pct = 0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (2 * SLOTS + 10) @(posedge clock);
      if (error_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule

// ===== filelist.f =====
design/gptt_pkg.sv
design/gptt_cell.sv
design/gptt_head.sv
design/grouped_periodic_timer_table_top.sv
test/tb_grouped_periodic_timer_table_top.sv
